### rtl/core/psg_pkg.sv
// Shared types and constants for the waveform pulse segmenter.
`default_nettype none
package psg_pkg;

   localparam int SAMPLE_BITS_DEFAULT   = 16;
   localparam int POSITION_BITS_DEFAULT = 16;

   // Widths fixed by the field definitions.
   localparam int FIELD_BITS     = 16;
   localparam int CUR_BITS       = 17;
   localparam int CSR_INDEX_BITS = 1;
   localparam int FIRST_INDEX    = 3;
   localparam int HIST_DEPTH     = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_VERTICAL_OFFSET = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NOISE_THRESHOLD = 1'd1;

   typedef struct packed {
      logic                  polarity;
      logic [FIELD_BITS-1:0] peak_position;
      logic [FIELD_BITS-1:0] peak_height;
      logic [FIELD_BITS-1:0] stop_position;
      logic [FIELD_BITS-1:0] start_position;
   } pulse_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

### rtl/core/psg_front.sv
// Front part: sample intake, offset correction and pulse segmentation.
`default_nettype none
module psg_front #(
   parameter int SAMPLE_BITS   = psg_pkg::SAMPLE_BITS_DEFAULT,
   parameter int POSITION_BITS = psg_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [psg_pkg::FIELD_BITS-1:0]        req_sample,
   input  wire logic                                  req_last,
   input  wire logic signed [psg_pkg::FIELD_BITS-1:0] vertical_offset,
   input  wire logic [psg_pkg::FIELD_BITS-1:0]        noise_threshold,
   input  wire psg_pkg::queue_status_type             queue_status,
   output logic                                       res_push,
   output psg_pkg::pulse_type                         res_data
);

   localparam int CB = psg_pkg::CUR_BITS;
   localparam int FB = psg_pkg::FIELD_BITS;
   localparam int HD = psg_pkg::HIST_DEPTH;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [POSITION_BITS-1:0] POS_FIRST = POSITION_BITS'(psg_pkg::FIRST_INDEX);

   // Intake stage: corrected sample and its index.
   logic                     a_valid_ff, a_valid_in;
   logic signed [CB-1:0]     a_cur_ff, a_cur_in;
   logic [FB-1:0]            a_mag_ff, a_mag_in;
   logic                     a_last_ff;
   logic [POSITION_BITS-1:0] a_idx_ff;
   logic [POSITION_BITS-1:0] idx_ff, idx_in;

   // Segmentation state.
   logic signed [CB-1:0]     hist_val_ff [HD];
   logic [FB-1:0]            hist_mag_ff [HD];
   logic                     edge_ff, edge_in;
   logic                     pulse_ff, pulse_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [FB-1:0]            best_mag_ff, best_mag_in;
   logic [POSITION_BITS-1:0] best_pos_ff, best_pos_in;
   logic                     best_neg_ff, best_neg_in;

   logic signed [SAMPLE_BITS-1:0] raw_sample;
   logic signed [CB-1:0]          abs_cur;
   logic accept, b_fire, active, crossing, ends, rising;

   assign b_fire    = a_valid_ff && !queue_status.full;
   assign req_ready = !a_valid_ff || b_fire;
   assign accept    = req_valid && req_ready;

   always_comb begin
      raw_sample = req_sample[SAMPLE_BITS-1:0];
      a_cur_in   = CB'(raw_sample) - CB'(vertical_offset);
      abs_cur    = a_cur_in[CB-1] ? -a_cur_in : a_cur_in;
      a_mag_in   = abs_cur[FB-1:0];
      a_valid_in = accept ? 1'b1 : (b_fire ? 1'b0 : a_valid_ff);
      if (accept && req_last) begin
         idx_in = '0;
      end else if (accept && idx_ff != POS_MAX) begin
         idx_in = idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         idx_ff     <= idx_in;
      end
      if (accept) begin
         a_cur_ff  <= a_cur_in;
         a_mag_ff  <= a_mag_in;
         a_last_ff <= req_last;
         a_idx_ff  <= idx_ff;
      end
   end

   // Segmentation of the sample held in the intake stage.
   always_comb begin
      active   = a_idx_ff >= POS_FIRST;
      crossing = (a_cur_ff > 0 && hist_val_ff[0] < 0) || (a_cur_ff < 0 && hist_val_ff[0] > 0);
      ends     = (a_mag_ff <= noise_threshold) || a_last_ff || crossing;
      rising   = (hist_mag_ff[2] < hist_mag_ff[1]) && (hist_mag_ff[1] < hist_mag_ff[0]) &&
                 (hist_mag_ff[0] < a_mag_ff);
      edge_in     = edge_ff;
      pulse_in    = pulse_ff;
      start_in    = start_ff;
      best_mag_in = best_mag_ff;
      best_pos_in = best_pos_ff;
      best_neg_in = best_neg_ff;
      if (b_fire && active) begin
         if (ends) begin
            edge_in  = 1'b0;
            pulse_in = 1'b0;
         end else begin
            if (!pulse_ff || a_mag_ff > best_mag_ff) begin
               best_mag_in = a_mag_ff;
               best_pos_in = a_idx_ff;
               best_neg_in = a_cur_ff[CB-1];
            end
            if (!pulse_ff) begin
               pulse_in = 1'b1;
               start_in = a_idx_ff;
            end
            if (!edge_ff && rising) begin
               edge_in = 1'b1;
            end
         end
      end
      if (b_fire && a_last_ff) begin
         edge_in  = 1'b0;
         pulse_in = 1'b0;
      end
   end

   assign res_push = b_fire && active && ends && edge_ff;

   always_comb begin
      res_data.start_position = FB'(start_ff);
      res_data.stop_position  = FB'(a_idx_ff - 1'b1);
      res_data.peak_height    = best_mag_ff;
      res_data.peak_position  = FB'(best_pos_ff);
      res_data.polarity       = best_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff  <= 1'b0;
         pulse_ff <= 1'b0;
      end else begin
         edge_ff  <= edge_in;
         pulse_ff <= pulse_in;
      end
      start_ff    <= start_in;
      best_mag_ff <= best_mag_in;
      best_pos_ff <= best_pos_in;
      best_neg_ff <= best_neg_in;
      // Indexes 0 to 2 of each waveform always refill the history before use.
      if (b_fire) begin
         hist_val_ff[0] <= a_cur_ff;
         hist_mag_ff[0] <= a_mag_ff;
         for (int i = 1; i < HD; i++) begin
            hist_val_ff[i] <= hist_val_ff[i-1];
            hist_mag_ff[i] <= hist_mag_ff[i-1];
         end
      end
   end

endmodule
`default_nettype wire

### rtl/core/psg_queue.sv
// Short result queue between the segmentation front and the output stage.
`default_nettype none
module psg_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire psg_pkg::pulse_type        push_data,
   input  wire logic                      pop,
   output psg_pkg::pulse_type             pop_data,
   output psg_pkg::queue_status_type      status
);

   localparam int DEPTH = psg_pkg::QUEUE_DEPTH;
   localparam int PB    = psg_pkg::QUEUE_PTR_BITS;

   psg_pkg::pulse_type entry_ff [DEPTH];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PB:0]   count_ff, count_in;
   logic do_push, do_pop;

   assign status.full  = count_ff == (PB+1)'(DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PB+1)'(do_push) - (PB+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### rtl/core/psg_back.sv
// Back part: output register that drives the result stream.
`default_nettype none
module psg_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire psg_pkg::queue_status_type queue_status,
   input  wire psg_pkg::pulse_type    queue_data,
   output logic                       queue_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output psg_pkg::pulse_type         rsp_data
);

   logic               valid_ff, valid_in;
   psg_pkg::pulse_type data_ff;

   assign queue_pop = !queue_status.empty && (!valid_ff || rsp_ready);
   assign valid_in  = queue_pop ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (queue_pop) begin
         data_ff <= queue_data;
      end
   end

endmodule
`default_nettype wire

### rtl/core/waveform_pulse_segmenter_core.sv
// Top level of the waveform pulse segmenter: ports, configuration and wiring.
//
// Digitizer samples enter on the req_ stream, one transaction per sample, with
// req_tlast marking the final sample of a waveform. Each sample has the
// vertical offset removed; from index 3 on, a sample inside the noise band, a
// sign change or the last sample closes the current segment. A segment that
// showed four strictly rising magnitudes produces one rsp_ transaction with
// start, stop, peak height, peak position and polarity.
// Throughput is one sample per cycle while the queue has room. A sample is
// registered in the intake stage and segmented there, which writes its result
// to a four-entry queue; the output register takes it from the queue when the
// output is free, and rsp_tvalid then rises. When rsp_tready is held low,
// results collect in the queue and the output register; once the queue is full
// the segmentation stage stops and req_tready drops until space frees up. No
// result is lost or repeated.
// Configuration goes through the csr_ port, which is always ready; index 0 is
// the vertical offset and index 1 the noise threshold. Write it only while idle.
// Reset clears both registers, the sample index, the pulse state and the queue.
`default_nettype none
module waveform_pulse_segmenter_core #(
   parameter int SAMPLE_BITS   = psg_pkg::SAMPLE_BITS_DEFAULT,
   parameter int POSITION_BITS = psg_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Sample stream.
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [psg_pkg::FIELD_BITS-1:0]        req_tdata,  // [15:0] sample
   input  wire logic                                  req_tlast,  // last_sample
   // Pulse result stream.
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [15:0] start_position, [31:16] stop_position, [47:32] peak_height,
   // [63:48] peak_position
   output logic [4*psg_pkg::FIELD_BITS-1:0]           rsp_tdata,
   output logic                                       rsp_tuser,  // polarity
   // Configuration writes.
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [psg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [psg_pkg::FIELD_BITS-1:0]        csr_data
);

   logic signed [psg_pkg::FIELD_BITS-1:0] offset_ff;
   logic [psg_pkg::FIELD_BITS-1:0]        threshold_ff;
   logic                                  csr_write;

   logic                      res_push;
   logic                      queue_pop;
   psg_pkg::pulse_type        res_data;
   psg_pkg::pulse_type        queue_data;
   psg_pkg::pulse_type        out_data;
   psg_pkg::queue_status_type queue_status;

   // The register file takes a write in every cycle.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         threshold_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            psg_pkg::REG_VERTICAL_OFFSET: offset_ff    <= csr_data;
            psg_pkg::REG_NOISE_THRESHOLD: threshold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   psg_front #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_sample      (req_tdata),
      .req_last        (req_tlast),
      .vertical_offset (offset_ff),
      .noise_threshold (threshold_ff),
      .queue_status    (queue_status),
      .res_push        (res_push),
      .res_data        (res_data)
   );

   psg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .pop       (queue_pop),
      .pop_data  (queue_data),
      .status    (queue_status)
   );

   psg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .queue_data   (queue_data),
      .queue_pop    (queue_pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_data     (out_data)
   );

   assign rsp_tdata = {out_data.peak_position, out_data.peak_height,
                       out_data.stop_position, out_data.start_position};
   assign rsp_tuser = out_data.polarity;

   // The front must never push a result into a full queue.
   assert property (@(posedge clock) disable iff (reset) queue_status.full |-> !res_push)
      else $error("result pushed into full queue");

   // Full and empty can never be reported together.
   assert property (@(posedge clock) disable iff (reset)
                    !(queue_status.full && queue_status.empty))
      else $error("queue reports full and empty at once");

   // Reset leaves the queue empty.
   assert property (@(posedge clock) reset |=> queue_status.empty)
      else $error("queue not empty after reset");

   // A result popped from the queue is on the output in the next cycle.
   assert property (@(posedge clock) disable iff (reset) queue_pop |=> rsp_tvalid)
      else $error("popped result not presented");

endmodule
`default_nettype wire
